// ===== rtl/core/pbfei_pkg.sv =====
package pbfei_pkg;

  localparam int FuncW   = 2;
  localparam int IndexW  = 6;
  localparam int OffsetW = 9;
  localparam int WidthW  = 7;
  localparam int WordW   = 64;
  localparam int ShiftW  = 6;

  localparam logic [FuncW-1:0] FUNC_WRITE   = 2'd0;
  localparam logic [FuncW-1:0] FUNC_READ    = 2'd1;
  localparam logic [FuncW-1:0] FUNC_EXTRACT = 2'd2;
  localparam logic [FuncW-1:0] FUNC_INSERT  = 2'd3;

  typedef logic [FuncW-1:0]   func_t;
  typedef logic [IndexW-1:0]  index_t;
  typedef logic [OffsetW-1:0] offset_t;
  typedef logic [WidthW-1:0]  width_t;
  typedef logic [WordW-1:0]   word_t;
  typedef logic [2*WordW-1:0] window_t;
  typedef logic [ShiftW-1:0]  shift_t;

endpackage

// ===== rtl/core/pbfei_req_if.sv =====
interface pbfei_req_if
  import pbfei_pkg::*;
;
  logic    valid;
  logic    ready;
  func_t   func;
  index_t  byte_index;
  offset_t bit_offset;
  width_t  field_width;
  word_t   data;

  modport source (
    output valid, func, byte_index, bit_offset, field_width, data,
    input  ready
  );
  modport sink (
    input  valid, func, byte_index, bit_offset, field_width, data,
    output ready
  );
endinterface

// ===== rtl/core/pbfei_rsp_if.sv =====
interface pbfei_rsp_if
  import pbfei_pkg::*;
;
  logic  valid;
  logic  ready;
  word_t field_value;
  logic  out_of_range;

  modport source (
    output valid, field_value, out_of_range,
    input  ready
  );
  modport sink (
    input  valid, field_value, out_of_range,
    output ready
  );
endinterface

// ===== rtl/core/pbfei_ram.sv =====
module pbfei_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/pbfei_field.sv =====
module pbfei_field
  import pbfei_pkg::*;
(
  input  window_t window,
  input  shift_t  shift,
  input  width_t  width,
  input  word_t   value,
  output word_t   extracted,
  output window_t merged
);

  word_t   mask;
  window_t mask_win;
  window_t value_win;
  window_t shifted;

  always_comb begin
    mask      = {WordW{1'b1}} >> (7'(WordW) - width);
    mask_win  = {{WordW{1'b0}}, mask} << shift;
    value_win = {{WordW{1'b0}}, value & mask} << shift;
    shifted   = window >> shift;
    extracted = shifted[WordW-1:0] & mask;
    merged    = (window & ~mask_win) | (value_win & mask_win);
  end

endmodule

// ===== rtl/core/packet_bit_field_extract_insert.sv =====
// Packet bit-field engine: holds a packet buffer and, per request, writes or
// reads one byte, or extracts or inserts a field of 1 to 64 bits at any bit
// offset (packet bit k is bit k mod 8 of byte k/8, field bit 0 at the offset).
// Every request gives one response; requests that fall outside the buffer or
// carry a bad width change nothing and answer with out_of_range set and a
// zero value. The buffer is stored as 64-bit words split into an even and an
// odd bank, so the two words a field can span are read together. A request
// first does the registered read of both banks, then shifts, merges, writes
// back and loads the response register once no older response is pending.
// A new request is taken while a response still waits to be taken. Buffer
// contents are undefined after reset until written.
module packet_bit_field_extract_insert
  import pbfei_pkg::*;
#(
  parameter int PKT_BYTES      = 64,
  parameter int MAX_FIELD_BITS = 64
) (
  input logic       clk,
  input logic       rst,
  pbfei_req_if.sink   req,
  pbfei_rsp_if.source rsp
);

  localparam int NumWords  = (PKT_BYTES + 7) / 8;
  localparam int BankDepth = (NumWords + 1) / 2;
  localparam int AddrW     = (BankDepth > 1) ? $clog2(BankDepth) : 1;
  localparam int TotalBits = PKT_BYTES * 8;

  typedef logic [AddrW-1:0] addr_t;

  logic    accept;
  logic    complete;
  logic    byte_op;
  offset_t eff_off;
  width_t  eff_w;
  word_t   eff_data;
  logic [OffsetW:0] end_bit;
  logic    field_ok;
  logic [2:0]  w0;
  logic [3:0]  w0_inc;
  logic [15:0] ea_wide;
  logic [15:0] oa_wide;
  logic [ShiftW+1:0] span;

  logic    busy;
  addr_t   ea;
  addr_t   oa;
  shift_t  shift;
  width_t  width;
  word_t   data;
  logic    do_extract;
  logic    do_write;
  logic    oor;
  logic    lo_odd;
  logic    touch_hi;

  logic    rsp_valid;
  word_t   rsp_value;
  logic    rsp_oor;

  word_t   even_rd;
  word_t   odd_rd;
  window_t window;
  window_t merged;
  word_t   extracted;
  logic    we_even;
  logic    we_odd;
  word_t   wd_even;
  word_t   wd_odd;

  assign accept   = req.valid && req.ready;
  assign complete = busy && (!rsp_valid || rsp.ready);
  assign req.ready = !busy;

  always_comb begin
    byte_op  = (req.func == FUNC_WRITE) || (req.func == FUNC_READ);
    eff_off  = byte_op ? {req.byte_index, 3'b000} : req.bit_offset;
    eff_w    = byte_op ? 7'd8 : req.field_width;
    eff_data = byte_op ? {{(WordW-8){1'b0}}, req.data[7:0]} : req.data;
    end_bit  = {1'b0, eff_off} + {3'b000, eff_w};
    field_ok = (eff_w != '0) && (32'(eff_w) <= 32'(MAX_FIELD_BITS))
               && (32'(end_bit) <= 32'(TotalBits));
    w0       = eff_off[OffsetW-1:ShiftW];
    w0_inc   = {1'b0, w0} + 4'd1;
    ea_wide  = {12'b0, 1'b0, w0_inc[3:1]};
    oa_wide  = {12'b0, 2'b00, w0[2:1]};
    span     = {2'b00, eff_off[ShiftW-1:0]} + {1'b0, eff_w};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (complete) begin
        busy <= 1'b0;
      end
      if (complete) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ea         <= ea_wide[AddrW-1:0];
      oa         <= oa_wide[AddrW-1:0];
      shift      <= eff_off[ShiftW-1:0];
      width      <= eff_w;
      data       <= eff_data;
      do_extract <= (req.func == FUNC_READ) || (req.func == FUNC_EXTRACT);
      do_write   <= (req.func == FUNC_WRITE) || (req.func == FUNC_INSERT);
      oor        <= !field_ok;
      lo_odd     <= w0[0];
      touch_hi   <= span > 8'(WordW);
    end
    if (complete) begin
      rsp_value <= (do_extract && !oor) ? extracted : '0;
      rsp_oor   <= oor;
    end
  end

  always_comb begin
    window  = lo_odd ? {even_rd, odd_rd} : {odd_rd, even_rd};
    we_even = complete && do_write && !oor && (lo_odd ? touch_hi : 1'b1);
    we_odd  = complete && do_write && !oor && (lo_odd ? 1'b1 : touch_hi);
    wd_even = lo_odd ? merged[2*WordW-1:WordW] : merged[WordW-1:0];
    wd_odd  = lo_odd ? merged[WordW-1:0] : merged[2*WordW-1:WordW];
  end

  pbfei_field u_field (
    .window    (window),
    .shift     (shift),
    .width     (width),
    .value     (data),
    .extracted (extracted),
    .merged    (merged)
  );

  pbfei_ram #(
    .WIDTH (WordW),
    .DEPTH (BankDepth)
  ) u_even (
    .clk   (clk),
    .we    (we_even),
    .waddr (ea),
    .wdata (wd_even),
    .re    (accept),
    .raddr (ea_wide[AddrW-1:0]),
    .rdata (even_rd)
  );

  pbfei_ram #(
    .WIDTH (WordW),
    .DEPTH (BankDepth)
  ) u_odd (
    .clk   (clk),
    .we    (we_odd),
    .waddr (oa),
    .wdata (wd_odd),
    .re    (accept),
    .raddr (oa_wide[AddrW-1:0]),
    .rdata (odd_rd)
  );

  assign rsp.valid        = rsp_valid;
  assign rsp.field_value  = rsp_value;
  assign rsp.out_of_range = rsp_oor;

endmodule
